FILE: hw/rtl/rpr_pkg.sv
// Shared types, codes and constants for the remote packet receiver.
package rpr_pkg;

  localparam int PACKET_BYTES = 16;
  localparam int POS_W = $clog2(PACKET_BYTES) + 1;
  localparam int IDX_W = $clog2(PACKET_BYTES);
  localparam int TICK_W = 17;
  localparam int ADDR_W = 40;
  localparam int TMO_W = 16;
  localparam int CFG_DATA_W = 40;

  // Function codes of an input word
  localparam logic [1:0] FUNC_BYTE  = 2'd0;
  localparam logic [1:0] FUNC_TICK  = 2'd1;
  localparam logic [1:0] FUNC_QUERY = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_ACK     = 2'd0;
  localparam logic [1:0] KIND_TIMEOUT = 2'd1;
  localparam logic [1:0] KIND_QUERY   = 2'd2;

  // Register indexes
  localparam logic REG_OWN_ADDRESS = 1'b0;
  localparam logic REG_TIMEOUT_MS  = 1'b1;

  localparam logic [TMO_W-1:0]  TIMEOUT_RESET = 16'd2000;
  localparam logic [TICK_W-1:0] TICK_MAX      = 17'h1FFFF;

  localparam logic [7:0] HDR_BYTE0   = 8'h01;
  localparam logic [7:0] HDR_BYTE1   = 8'h03;
  localparam logic [7:0] ACK_BYTE1   = 8'h83;
  localparam logic [7:0] ACK_BYTE3   = 8'd11;
  localparam logic [7:0] STICK_IDLE  = 8'h80;
  localparam logic [7:0] ACK_HDR_SUM = 8'h8F;  // 01 + 83h + 11
  localparam int SUM_BYTE    = 15;
  localparam int BUTTON_BYTE = 8;
  localparam int SEQ_BYTE    = 2;
  localparam int ECHO_FIRST  = 9;

  typedef logic [PACKET_BYTES-1:0][7:0] pkt_bytes_t;

  // Store after reset or timeout: zeros, stick bytes 4..7 at center
  localparam pkt_bytes_t STORE_INIT = {
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    STICK_IDLE, STICK_IDLE, STICK_IDLE, STICK_IDLE, 8'h00, 8'h00, 8'h00, 8'h00
  };

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data_byte;
    logic       first;
    logic [3:0] index;
    logic [7:0] mask;
  } in_word_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       last;
    logic       pressed;
    logic       link_ok;
  } out_word_t;

  // Result job handed from the core to the output stage
  typedef struct packed {
    logic       valid;
    logic       burst;
    logic [1:0] kind;
    pkt_bytes_t bytes;
    logic       pressed;
    logic       link_ok;
  } job_t;

endpackage

FILE: hw/rtl/remote_packet_receiver_ack.sv
// Top level of the remote packet receiver with acknowledgement.
//
//   port group  direction  handshake            word
//   in_*        input      in_valid/in_stall    rpr_pkg::in_word_t
//   out_*       output     out_valid/out_stall  rpr_pkg::out_word_t
//   cfg_*       input      cfg_we               index 0 own_address, 1 timeout_ms
//
// One input word is taken per cycle; state updates at that edge and any result
// is registered, so the first output word is offered the next cycle.
// A valid packet's final byte yields 16 output words; input stalls until the last leaves.
// Any input word stalls while the output register holds a word that is not leaving.
// Synchronous active-low reset; no clearing pass is needed after it.
module remote_packet_receiver_ack (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  rpr_pkg::in_word_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output rpr_pkg::out_word_t            out_data,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [rpr_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic          accept;
  logic          hold;
  rpr_pkg::job_t job;

  assign in_stall = hold;
  assign accept   = in_valid && !hold;

  rpr_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_word   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .job       (job)
  );

  rpr_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (job),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .hold      (hold)
  );

endmodule

FILE: hw/rtl/rpr_core.sv
// Receive state, payload store, link timer and result job generation.
module rpr_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  rpr_pkg::in_word_t             in_word,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [rpr_pkg::CFG_DATA_W-1:0] cfg_data,
  output rpr_pkg::job_t                 job
);

  logic [rpr_pkg::ADDR_W-1:0] own_addr_r;
  logic [rpr_pkg::TMO_W-1:0]  timeout_r;
  logic [7:0]                 inc_r [rpr_pkg::SUM_BYTE];
  rpr_pkg::pkt_bytes_t        store_r;
  logic [rpr_pkg::POS_W-1:0]  pos_r;
  logic [7:0]                 sum_r;
  logic [7:0]                 part_r;
  logic [rpr_pkg::TICK_W-1:0] tick_r;
  logic                       link_r;

  logic [rpr_pkg::POS_W-1:0]  pos_eff;
  logic [7:0]                 sum_eff;
  logic [7:0]                 part_eff;
  logic                       is_byte;
  logic                       is_tick;
  logic                       is_query;
  logic                       rx_active;
  logic                       rx_final;
  logic                       pkt_good;
  logic                       echo_pos;
  logic [rpr_pkg::TICK_W-1:0] tick_inc;
  logic                       tmo_fire;
  logic [7:0]                 addr_sum;
  rpr_pkg::pkt_bytes_t        ack_bytes;
  rpr_pkg::pkt_bytes_t        rx_bytes;

  assign is_byte  = accept && (in_word.func == rpr_pkg::FUNC_BYTE);
  assign is_tick  = accept && (in_word.func == rpr_pkg::FUNC_TICK);
  assign is_query = accept && (in_word.func == rpr_pkg::FUNC_QUERY);

  // A first byte restarts reception regardless of where we were
  assign pos_eff  = in_word.first ? '0 : pos_r;
  assign sum_eff  = in_word.first ? '0 : sum_r;
  assign part_eff = in_word.first ? '0 : part_r;

  assign rx_active = is_byte && !pos_eff[rpr_pkg::POS_W-1];
  assign rx_final  = rx_active && (pos_eff == rpr_pkg::POS_W'(rpr_pkg::SUM_BYTE));
  assign pkt_good  = rx_final && (inc_r[0] == rpr_pkg::HDR_BYTE0) &&
                     (inc_r[1] == rpr_pkg::HDR_BYTE1) && (in_word.data_byte == sum_eff);

  // Sequence byte and bytes 9..14 are echoed into the acknowledgement
  assign echo_pos = (pos_eff == rpr_pkg::POS_W'(rpr_pkg::SEQ_BYTE)) ||
                    (pos_eff >= rpr_pkg::POS_W'(rpr_pkg::ECHO_FIRST));

  assign tick_inc = (tick_r != rpr_pkg::TICK_MAX) ? tick_r + 1'b1 : tick_r;
  assign tmo_fire = tick_inc > {1'b0, timeout_r};

  assign addr_sum = own_addr_r[7:0] + own_addr_r[15:8] + own_addr_r[23:16] +
                    own_addr_r[31:24] + own_addr_r[39:32];

  always_comb begin
    for (int i = 0; i < rpr_pkg::SUM_BYTE; i++) begin
      rx_bytes[i] = inc_r[i];
    end
    rx_bytes[rpr_pkg::SUM_BYTE] = in_word.data_byte;

    ack_bytes = rx_bytes;
    ack_bytes[0] = rpr_pkg::HDR_BYTE0;
    ack_bytes[1] = rpr_pkg::ACK_BYTE1;
    ack_bytes[3] = rpr_pkg::ACK_BYTE3;
    for (int i = 0; i < 5; i++) begin
      ack_bytes[4 + i] = own_addr_r[8*i +: 8];
    end
    ack_bytes[rpr_pkg::SUM_BYTE] = rpr_pkg::ACK_HDR_SUM + part_eff + addr_sum;
  end

  always_comb begin
    job = '0;
    if (pkt_good) begin
      job.valid   = 1'b1;
      job.burst   = 1'b1;
      job.kind    = rpr_pkg::KIND_ACK;
      job.bytes   = ack_bytes;
      job.link_ok = 1'b1;
    end else if (is_tick && tmo_fire) begin
      job.valid = 1'b1;
      job.kind  = rpr_pkg::KIND_TIMEOUT;
    end else if (is_query) begin
      job.valid    = 1'b1;
      job.kind     = rpr_pkg::KIND_QUERY;
      job.bytes[0] = store_r[in_word.index];
      job.pressed  = |(store_r[rpr_pkg::BUTTON_BYTE] & in_word.mask);
      job.link_ok  = link_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_addr_r <= '0;
      timeout_r  <= rpr_pkg::TIMEOUT_RESET;
      store_r    <= rpr_pkg::STORE_INIT;
      pos_r      <= rpr_pkg::POS_W'(rpr_pkg::PACKET_BYTES);
      sum_r      <= '0;
      part_r     <= '0;
      tick_r     <= '0;
      link_r     <= 1'b1;
    end else begin
      if (cfg_we) begin
        if (cfg_index == rpr_pkg::REG_OWN_ADDRESS) begin
          own_addr_r <= cfg_data[rpr_pkg::ADDR_W-1:0];
        end else begin
          timeout_r <= cfg_data[rpr_pkg::TMO_W-1:0];
        end
      end
      if (is_byte) begin
        if (rx_final) begin
          pos_r  <= rpr_pkg::POS_W'(rpr_pkg::PACKET_BYTES);
          sum_r  <= sum_eff;
          part_r <= part_eff;
        end else if (rx_active) begin
          pos_r  <= pos_eff + 1'b1;
          sum_r  <= sum_eff + in_word.data_byte;
          part_r <= echo_pos ? part_eff + in_word.data_byte : part_eff;
        end else begin
          pos_r  <= pos_eff;
          sum_r  <= sum_eff;
          part_r <= part_eff;
        end
      end
      if (pkt_good) begin
        store_r <= rx_bytes;
        link_r  <= 1'b1;
        tick_r  <= '0;
      end
      if (is_tick) begin
        if (tmo_fire) begin
          tick_r  <= '0;
          store_r <= rpr_pkg::STORE_INIT;
          link_r  <= 1'b0;
        end else begin
          tick_r <= tick_inc;
        end
      end
    end
  end

  // Incoming buffer has no reset; only positions of the current payload are read
  always_ff @(posedge clk) begin
    if (rx_active && !rx_final) begin
      inc_r[pos_eff[rpr_pkg::IDX_W-1:0]] <= in_word.data_byte;
    end
  end

`ifndef SYNTH
  a_link_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(link_r) |-> $past(is_tick && tmo_fire))
    else $error("link dropped without a timeout");
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= rpr_pkg::POS_W'(rpr_pkg::PACKET_BYTES))
    else $error("byte position out of range");
  a_good_tick_clear: assert property (@(posedge clk) disable iff (!rst_n)
    pkt_good |=> (tick_r == '0) && link_r)
    else $error("accepted packet did not restart link timer");
`endif

endmodule

FILE: hw/rtl/rpr_out.sv
// Output register: holds a single result or shifts out a 16-word acknowledgement.
module rpr_out (
  input  logic                clk,
  input  logic                rst_n,
  input  rpr_pkg::job_t       job,
  input  logic                out_stall,
  output logic                out_valid,
  output rpr_pkg::out_word_t  out_data,
  output logic                hold
);

  logic                   valid_r;
  logic                   burst_r;
  logic [rpr_pkg::IDX_W-1:0] cnt_r;
  logic [1:0]             kind_r;
  rpr_pkg::pkt_bytes_t    bytes_r;
  logic                   pressed_r;
  logic                   link_r;
  logic                   pop;
  logic                   last;

  assign last = !burst_r || (cnt_r == rpr_pkg::IDX_W'(rpr_pkg::PACKET_BYTES - 1));
  assign pop  = valid_r && !out_stall;
  // Free again in the cycle the final word leaves
  assign hold = valid_r && !(pop && last);

  assign out_valid         = valid_r;
  assign out_data.kind     = kind_r;
  assign out_data.out_byte = bytes_r[0];
  assign out_data.last     = last;
  assign out_data.pressed  = pressed_r;
  assign out_data.link_ok  = link_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      burst_r <= 1'b0;
      cnt_r   <= '0;
    end else if (job.valid) begin
      valid_r <= 1'b1;
      burst_r <= job.burst;
      cnt_r   <= '0;
    end else if (pop) begin
      if (last) begin
        valid_r <= 1'b0;
        burst_r <= 1'b0;
        cnt_r   <= '0;
      end else begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job.valid) begin
      kind_r    <= job.kind;
      bytes_r   <= job.bytes;
      pressed_r <= job.pressed;
      link_r    <= job.link_ok;
    end else if (pop) begin
      bytes_r <= {8'h00, bytes_r[rpr_pkg::PACKET_BYTES-1:1]};
    end
  end

`ifndef SYNTH
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    job.valid |-> !hold)
    else $error("new result job while output still busy");
  a_cnt_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) |-> (burst_r && valid_r))
    else $error("word count running outside an acknowledgement");
  a_burst_step: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !last && !job.valid) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("acknowledgement word skipped or repeated");
`endif

endmodule

FILE: dv/rpr_result_checker.sv
// Result checker for the remote packet receiver: tracks receiver state and compares out words.
`timescale 1ns / 1ps

module rpr_result_checker
  import rpr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_word_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_word_t             out_data,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    pending,
  output int                    words_in,
  output int                    acks_seen,
  output int                    timeouts_seen,
  output int                    queries_seen
);

  localparam int PRINT_CAP = 40;

  logic [7:0]        rx_buf [PACKET_BYTES];
  logic [7:0]        store [PACKET_BYTES];
  logic [POS_W-1:0]  rx_pos;
  logic [7:0]        rx_sum;
  logic [TICK_W-1:0] ms_ticks;
  logic              link_up;
  logic [ADDR_W-1:0] own_addr;
  logic [TMO_W-1:0]  tmo_limit;
  out_word_t         expected_words [$];

  task automatic report_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
    if (errors < PRINT_CAP)
      $display("mismatch at %0t ns: %s expected %02h got %02h", $time, what, want, got);
    errors++;
  endtask

  task automatic clear_store();
    for (int i = 0; i < PACKET_BYTES; i++) store[i] = STORE_INIT[i];
  endtask

  task automatic push_result(input logic [1:0] kind, input logic [7:0] b, input logic lst,
                             input logic prs, input logic ok);
    out_word_t r;
    r.kind = kind;
    r.out_byte = b;
    r.last = lst;
    r.pressed = prs;
    r.link_ok = ok;
    expected_words.push_back(r);
  endtask

  // Applies one accepted input word to the tracked state and queues what it produces.
  task automatic advance_receiver(input in_word_t w);
    logic [7:0] ack [PACKET_BYTES];
    logic [7:0] s;
    case (w.func)
      FUNC_BYTE: begin
        if (w.first) begin
          rx_pos = '0;
          rx_sum = '0;
        end
        if (rx_pos < PACKET_BYTES) begin
          rx_buf[rx_pos[IDX_W-1:0]] = w.data_byte;
          if (rx_pos < SUM_BYTE) begin
            rx_sum = rx_sum + w.data_byte;
            rx_pos = rx_pos + 1'b1;
          end else begin
            rx_pos = POS_W'(PACKET_BYTES);
            if (rx_buf[0] == HDR_BYTE0 && rx_buf[1] == HDR_BYTE1 &&
                rx_buf[SUM_BYTE] == rx_sum) begin
              store = rx_buf;
              link_up = 1'b1;
              ms_ticks = '0;
              ack = rx_buf;
              ack[0] = HDR_BYTE0;
              ack[1] = ACK_BYTE1;
              ack[3] = ACK_BYTE3;
              for (int i = 0; i < 5; i++) ack[4 + i] = own_addr[8*i +: 8];
              s = '0;
              for (int i = 0; i < SUM_BYTE; i++) s = s + ack[i];
              ack[SUM_BYTE] = s;
              for (int i = 0; i < PACKET_BYTES; i++)
                push_result(KIND_ACK, ack[i], i == PACKET_BYTES - 1, 1'b0, 1'b1);
            end
          end
        end
      end
      FUNC_TICK: begin
        if (ms_ticks < TICK_MAX) ms_ticks = ms_ticks + 1'b1;
        if (ms_ticks > tmo_limit) begin
          ms_ticks = '0;
          clear_store();
          link_up = 1'b0;
          push_result(KIND_TIMEOUT, 8'h00, 1'b1, 1'b0, 1'b0);
        end
      end
      FUNC_QUERY: begin
        push_result(KIND_QUERY, store[w.index], 1'b1,
                    |(store[BUTTON_BYTE] & w.mask), link_up);
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_output(input out_word_t got);
    out_word_t want;
    if (expected_words.size() == 0) begin
      report_mismatch("unexpected out word, byte", 8'h00, got.out_byte);
    end else begin
      want = expected_words.pop_front();
      if (got.kind !== want.kind) report_mismatch("kind", 8'(want.kind), 8'(got.kind));
      if (got.out_byte !== want.out_byte) report_mismatch("out_byte", want.out_byte, got.out_byte);
      if (got.last !== want.last) report_mismatch("last", 8'(want.last), 8'(got.last));
      if (got.pressed !== want.pressed)
        report_mismatch("pressed", 8'(want.pressed), 8'(got.pressed));
      if (got.link_ok !== want.link_ok)
        report_mismatch("link_ok", 8'(want.link_ok), 8'(got.link_ok));
      if (want.kind == KIND_ACK && want.last) acks_seen++;
      if (want.kind == KIND_TIMEOUT) timeouts_seen++;
      if (want.kind == KIND_QUERY) queries_seen++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PACKET_BYTES; i++) rx_buf[i] = '0;
      clear_store();
      rx_pos = POS_W'(PACKET_BYTES);
      rx_sum = '0;
      ms_ticks = '0;
      link_up = 1'b1;
      own_addr = '0;
      tmo_limit = TIMEOUT_RESET;
      expected_words.delete();
      errors = 0;
      words_in = 0;
      acks_seen = 0;
      timeouts_seen = 0;
      queries_seen = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_OWN_ADDRESS: own_addr = cfg_data[ADDR_W-1:0];
          REG_TIMEOUT_MS:  tmo_limit = cfg_data[TMO_W-1:0];
          default: begin
          end
        endcase
      end
      // input first: results queue behind older ones, so same-edge ordering is harmless
      if (in_valid && !in_stall) begin
        advance_receiver(in_data);
        words_in++;
      end
      if (out_valid && !out_stall) check_output(out_data);
    end
    pending = expected_words.size();
  end

endmodule

FILE: dv/tb_remote_packet_receiver_ack.sv
// Testbench top for the remote packet receiver: stimulus, flow control, watchdog and verdict.
`timescale 1ns / 1ps

module tb_remote_packet_receiver_ack;
  import rpr_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int QUIET_LIMIT   = 2000;
  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_WORDS   = 50;
  localparam int SETTLE_CYCLES = 4;
  localparam int SHORT_LIMIT   = 5;
  localparam int FEW_TICKS     = 8;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_word_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_word_t             out_data;
  logic                  cfg_we;
  logic                  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int errors, pending, words_in, acks_seen, timeouts_seen, queries_seen;
  int quiet_cycles;
  bit idle_on;

  remote_packet_receiver_ack dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rpr_result_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .errors        (errors),
    .pending       (pending),
    .words_in      (words_in),
    .acks_seen     (acks_seen),
    .timeouts_seen (timeouts_seen),
    .queries_seen  (queries_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: no handshake on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver side: random stall before each out word
  initial begin
    int n;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      n = idle_on ? $urandom_range(0, 10) : 0;
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
      @(negedge clk);
    end
  end

  function automatic in_word_t noise_word();
    logic [31:0] r;
    r = $urandom;
    return in_word_t'(r[$bits(in_word_t)-1:0]);
  endfunction

  function automatic in_word_t byte_word(input logic [7:0] b, input logic f);
    in_word_t w;
    w = noise_word();
    w.func = FUNC_BYTE;
    w.data_byte = b;
    w.first = f;
    return w;
  endfunction

  function automatic in_word_t tick_word();
    in_word_t w;
    w = noise_word();
    w.func = FUNC_TICK;
    return w;
  endfunction

  function automatic in_word_t query_word(input logic [3:0] idx, input logic [7:0] m);
    in_word_t w;
    w = noise_word();
    w.func = FUNC_QUERY;
    w.index = idx;
    w.mask = m;
    return w;
  endfunction

  function automatic pkt_bytes_t seal(input pkt_bytes_t p);
    logic [7:0] s;
    s = '0;
    for (int i = 0; i < SUM_BYTE; i++) s = s + p[i];
    p[SUM_BYTE] = s;
    return p;
  endfunction

  function automatic pkt_bytes_t good_packet();
    pkt_bytes_t p;
    for (int i = 0; i < PACKET_BYTES; i++) p[i] = 8'($urandom_range(0, 255));
    p[0] = HDR_BYTE0;
    p[1] = HDR_BYTE1;
    return seal(p);
  endfunction

  // Called at a falling edge, returns at the falling edge after acceptance with valid still up.
  task automatic send_word(input in_word_t w);
    int gap;
    gap = idle_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold off the sender until every expected word has come out, then let the block settle.
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_word(tick_word());
  endtask

  // optionally interleave ticks and queries between payload bytes
  task automatic send_packet(input pkt_bytes_t p, input bit mixed);
    for (int i = 0; i < PACKET_BYTES; i++) begin
      if (mixed && $urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1) != 0)
          send_word(tick_word());
        else
          send_word(query_word(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255))));
      end
      send_word(byte_word(p[i], i == 0));
    end
  endtask

  task automatic run_random(input int n_words);
    int done, sel, flaw, k;
    pkt_bytes_t p, q;
    in_word_t w;
    done = 0;
    while (done < n_words) begin
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        p = good_packet();
        flaw = $urandom_range(0, 9);
        case (flaw)
          0: p[$urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
          1: p[SUM_BYTE] ^= 8'($urandom_range(1, 255));
          2: begin
            // partial payload, then restart with first set
            q = good_packet();
            k = $urandom_range(1, 15);
            for (int j = 0; j < k; j++) send_word(byte_word(q[j], j == 0));
            done += k;
          end
          default: begin
          end
        endcase
        send_packet(p, 1'b1);
        done += PACKET_BYTES;
      end else if (sel < 70) begin
        send_word(tick_word());
        done++;
      end else if (sel < 88) begin
        send_word(query_word(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255))));
        done++;
      end else begin
        w = noise_word();
        send_word(w);
        if (w.func != FUNC_UNUSED) done++;
      end
    end
  endtask

  initial begin
    pkt_bytes_t p;
    in_word_t w;
    logic [63:0] r64;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = REG_OWN_ADDRESS;
    cfg_data = '0;
    idle_on = 1'b1;
    quiet_cycles = 0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, register values from reset
    send_word(query_word(4'd4, 8'hFF));
    send_word(byte_word(8'h01, 1'b0));  // no start seen: ignored
    w = noise_word();
    w.func = FUNC_UNUSED;
    send_word(w);
    p = good_packet();
    p[SEQ_BYTE] = 8'hFF;
    p[BUTTON_BYTE] = 8'hA5;
    p[14] = 8'h00;
    send_packet(seal(p), 1'b0);
    send_word(query_word(4'(BUTTON_BYTE), 8'h5A));
    send_word(query_word(4'(BUTTON_BYTE), 8'h01));
    send_word(query_word(4'd15, 8'h00));
    send_word(tick_word());

    // short limit: the store resets once the count passes it
    pause_until_drained();
    write_reg(REG_TIMEOUT_MS, CFG_DATA_W'(SHORT_LIMIT));
    idle_on = 1'b0;
    send_ticks(SHORT_LIMIT + 1);
    send_word(query_word(4'd0, 8'hFF));
    pause_until_drained();

    write_reg(REG_OWN_ADDRESS, {CFG_DATA_W{1'b1}});
    write_reg(REG_TIMEOUT_MS, CFG_DATA_W'(0));
    idle_on = 1'b1;
    send_word(tick_word());
    send_word(query_word(4'd4, 8'hFF));
    send_packet(good_packet(), 1'b0);
    send_word(query_word(4'd15, 8'hFF));
    pause_until_drained();

    // largest limit: a few ticks never fire
    write_reg(REG_TIMEOUT_MS, CFG_DATA_W'(16'hFFFF));
    idle_on = 1'b0;
    send_ticks(FEW_TICKS);
    send_word(query_word(4'd5, 8'hFF));
    pause_until_drained();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      r64 = {$urandom, $urandom};
      case (ph)
        0: begin
          write_reg(REG_OWN_ADDRESS, r64[CFG_DATA_W-1:0]);
          write_reg(REG_TIMEOUT_MS, CFG_DATA_W'($urandom_range(0, 25)));
          idle_on = 1'b1;
        end
        1: begin
          write_reg(REG_OWN_ADDRESS, CFG_DATA_W'(0));
          write_reg(REG_TIMEOUT_MS, CFG_DATA_W'(16'hFFFF));
          idle_on = 1'b0;
        end
        2: begin
          write_reg(REG_OWN_ADDRESS, {CFG_DATA_W{1'b1}});
          write_reg(REG_TIMEOUT_MS, CFG_DATA_W'(0));
          idle_on = 1'b1;
        end
        3: begin
          write_reg(REG_OWN_ADDRESS, r64[CFG_DATA_W-1:0]);
          write_reg(REG_TIMEOUT_MS, CFG_DATA_W'($urandom_range(1, 12)));
          idle_on = 1'b1;
        end
        default: begin
          write_reg(REG_OWN_ADDRESS, r64[CFG_DATA_W-1:0]);
          write_reg(REG_TIMEOUT_MS, CFG_DATA_W'($urandom_range(0, 65535)));
          idle_on = 1'b1;
        end
      endcase
      run_random(PHASE_WORDS);
      pause_until_drained();
    end

    repeat (2 * SETTLE_CYCLES) @(negedge clk);
    $display("covered %0d input words: %0d acks, %0d timeouts, %0d query answers",
             words_in, acks_seen, timeouts_seen, queries_seen);
    $display("register sets: reset values, address 0 / all ones / random, limit 0 to 65535");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/rpr_pkg.sv
hw/rtl/rpr_core.sv
hw/rtl/rpr_out.sv
hw/rtl/remote_packet_receiver_ack.sv
dv/rpr_result_checker.sv
dv/tb_remote_packet_receiver_ack.sv
